/* sv/imusd_pkg.sv */
// ----------------------------------------------------------------------------
// imusd_pkg
// Shared types, constants and tables of the IMU strike detector.
// ----------------------------------------------------------------------------
`default_nettype none

package imusd_pkg;

  localparam int CORDIC_STEPS      = 16;
  localparam int CURVE_TABLE_DEPTH = 256;

  localparam int CORDIC_ITER = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int SQRT_STEPS  = 18;
  localparam int CNT_W = $clog2((CORDIC_ITER > SQRT_STEPS) ? CORDIC_ITER : SQRT_STEPS);
  localparam int VEL_W = $clog2(CURVE_TABLE_DEPTH);

  localparam int ANG_FULL    = 5898240;
  localparam int ANG_HALF    = 2949120;
  localparam int ANG_QUARTER = 1474560;
  localparam int ANG_MAX     = 8388607;
  localparam int GAIN_Q24    = 10188014;
  localparam int THR_UP      = 10486;
  localparam int THR_DOWN    = 5243;
  localparam int GYRO_SCALE  = 81965;
  localparam int BLEND_OLD   = 32113;
  localparam int BLEND_ACC   = 655;
  localparam int PEAK_LO     = 4096;
  localparam int PEAK_HI     = 32768;
  localparam int PEAK_SPAN   = 28672;
  localparam int RECIP7      = 37449;
  localparam int RECIP7_SH   = 18;
  localparam int VEL_BASE    = 40;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FLOOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_ROLL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_PITCH  = 3'd5;

  localparam logic [CNT_W-1:0] SQ_AY = CNT_W'(0);
  localparam logic [CNT_W-1:0] SQ_AZ = CNT_W'(1);
  localparam logic [CNT_W-1:0] SQ_EX = CNT_W'(2);
  localparam logic [CNT_W-1:0] SQ_EY = CNT_W'(3);
  localparam logic [CNT_W-1:0] SQ_EZ = CNT_W'(4);

  localparam logic [6:0] NOTE_CENTER   = 7'd38;
  localparam logic [6:0] NOTE_LEFT     = 7'd42;
  localparam logic [6:0] NOTE_RIGHT    = 7'd49;
  localparam logic [6:0] NOTE_OVERHEAD = 7'd55;

  localparam logic [19:0] ATAN_TAB [24] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
    20'd14667, 20'd7334, 20'd3667, 20'd1833, 20'd917, 20'd458, 20'd229,
    20'd115, 20'd57, 20'd29, 20'd14, 20'd7, 20'd4, 20'd2, 20'd1, 20'd0,
    20'd0, 20'd0
  };

  typedef enum logic [1:0] {
    ZONE_CENTER,
    ZONE_LEFT,
    ZONE_RIGHT,
    ZONE_OVERHEAD
  } zone_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_FIRST,
    OP_SQ_ADD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_VEC_INIT,
    OP_CORDIC_STEP,
    OP_VEC_SAVE,
    OP_GYRO,
    OP_BLEND_A,
    OP_BLEND_B,
    OP_ROT_INIT,
    OP_ROT_SAVE,
    OP_GRAV_A,
    OP_GRAV_B,
    OP_DECIDE,
    OP_VEL_A,
    OP_VEL_B
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             sel;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } sts_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic [6:0] drum_note;
    logic [1:0] zone;
    logic [6:0] strike_velocity;
  } out_t;

  typedef logic [6:0] vel_rom_t [CURVE_TABLE_DEPTH];

  function automatic vel_rom_t build_vel_rom();
    vel_rom_t    rom;
    logic [63:0] d1;
    logic [63:0] d3;
    logic [63:0] rhs;
    logic [63:0] k5;
    logic [63:0] k;
    d1 = 64'(CURVE_TABLE_DEPTH - 1);
    d3 = d1 * d1 * d1;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      rhs = 64'(i) * 64'(i) * 64'(i) * 64'd4984209207;
      k = 64'd0;
      for (int j = 1; j <= 87; j++) begin
        k5 = 64'(j) * 64'(j) * 64'(j) * 64'(j) * 64'(j);
        if (k5 * d3 <= rhs) begin
          k = 64'(j);
        end
      end
      rom[i] = 7'(64'(VEL_BASE) + k);
    end
    return rom;
  endfunction

  localparam vel_rom_t VEL_ROM = build_vel_rom();

  function automatic logic [6:0] note_of(zone_t z);
    logic [6:0] n;
    unique case (z)
      ZONE_LEFT:     n = NOTE_LEFT;
      ZONE_RIGHT:    n = NOTE_RIGHT;
      ZONE_OVERHEAD: n = NOTE_OVERHEAD;
      default:       n = NOTE_CENTER;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* sv/imusd_ctrl.sv */
// ----------------------------------------------------------------------------
// imusd_ctrl
// Sequencer that steps the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module imusd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  imusd_pkg::sts_t     sts,
  output imusd_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_AY,
    S_SQ_AZ,
    S_SQRT_INIT,
    S_SQRT,
    S_VEC_INIT,
    S_VEC,
    S_VEC_SAVE,
    S_GYRO,
    S_BLEND_A,
    S_BLEND_B,
    S_ROT_INIT,
    S_ROT,
    S_ROT_SAVE,
    S_GRAV_A,
    S_GRAV_B,
    S_SQ_EX,
    S_SQ_EY,
    S_SQ_EZ,
    S_DECIDE,
    S_VEL_A,
    S_VEL_B
  } state_t;

  localparam logic [imusd_pkg::CNT_W-1:0] CORDIC_LAST =
    imusd_pkg::CNT_W'(imusd_pkg::CORDIC_ITER - 1);
  localparam logic [imusd_pkg::CNT_W-1:0] SQRT_LAST =
    imusd_pkg::CNT_W'(imusd_pkg::SQRT_STEPS - 1);

  state_t                        state;
  logic [imusd_pkg::CNT_W-1:0]   cnt;
  logic                          sel;
  logic                          late;
  logic                          out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !(out_valid && out_stall);

  always_comb begin
    cmd.op  = imusd_pkg::OP_NONE;
    cmd.sel = sel;
    cmd.idx = cnt;
    unique case (state)
      S_IDLE:      cmd.op = in_valid ? imusd_pkg::OP_LOAD : imusd_pkg::OP_NONE;
      S_SQ_AY: begin
        cmd.op  = imusd_pkg::OP_SQ_FIRST;
        cmd.idx = imusd_pkg::SQ_AY;
      end
      S_SQ_AZ: begin
        cmd.op  = imusd_pkg::OP_SQ_ADD;
        cmd.idx = imusd_pkg::SQ_AZ;
      end
      S_SQRT_INIT: cmd.op = imusd_pkg::OP_SQRT_INIT;
      S_SQRT:      cmd.op = imusd_pkg::OP_SQRT_STEP;
      S_VEC_INIT:  cmd.op = imusd_pkg::OP_VEC_INIT;
      S_VEC:       cmd.op = imusd_pkg::OP_CORDIC_STEP;
      S_VEC_SAVE:  cmd.op = imusd_pkg::OP_VEC_SAVE;
      S_GYRO:      cmd.op = imusd_pkg::OP_GYRO;
      S_BLEND_A:   cmd.op = imusd_pkg::OP_BLEND_A;
      S_BLEND_B:   cmd.op = imusd_pkg::OP_BLEND_B;
      S_ROT_INIT:  cmd.op = imusd_pkg::OP_ROT_INIT;
      S_ROT:       cmd.op = imusd_pkg::OP_CORDIC_STEP;
      S_ROT_SAVE:  cmd.op = imusd_pkg::OP_ROT_SAVE;
      S_GRAV_A:    cmd.op = imusd_pkg::OP_GRAV_A;
      S_GRAV_B:    cmd.op = imusd_pkg::OP_GRAV_B;
      S_SQ_EX: begin
        cmd.op  = imusd_pkg::OP_SQ_FIRST;
        cmd.idx = imusd_pkg::SQ_EX;
      end
      S_SQ_EY: begin
        cmd.op  = imusd_pkg::OP_SQ_ADD;
        cmd.idx = imusd_pkg::SQ_EY;
      end
      S_SQ_EZ: begin
        cmd.op  = imusd_pkg::OP_SQ_ADD;
        cmd.idx = imusd_pkg::SQ_EZ;
      end
      S_DECIDE:    cmd.op = imusd_pkg::OP_DECIDE;
      S_VEL_A:     cmd.op = imusd_pkg::OP_VEL_A;
      S_VEL_B:     cmd.op = out_free ? imusd_pkg::OP_VEL_B : imusd_pkg::OP_NONE;
      default:     cmd.op = imusd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sel       <= 1'b0;
      late      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQ_AY;
            sel   <= 1'b0;
            late  <= 1'b0;
          end
        end
        S_SQ_AY:     state <= S_SQ_AZ;
        S_SQ_AZ:     state <= S_SQRT_INIT;
        S_SQRT_INIT: begin
          state <= S_SQRT;
          cnt   <= '0;
        end
        S_SQRT: begin
          if (cnt == SQRT_LAST) begin
            state <= late ? S_DECIDE : S_VEC_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_VEC_INIT: begin
          state <= S_VEC;
          cnt   <= '0;
        end
        S_VEC: begin
          if (cnt == CORDIC_LAST) begin
            state <= S_VEC_SAVE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_VEC_SAVE: begin
          state <= sel ? S_GYRO : S_VEC_INIT;
          sel   <= !sel;
        end
        S_GYRO:      state <= S_BLEND_A;
        S_BLEND_A:   state <= S_BLEND_B;
        S_BLEND_B: begin
          state <= sel ? S_ROT_INIT : S_GYRO;
          sel   <= !sel;
        end
        S_ROT_INIT: begin
          state <= S_ROT;
          cnt   <= '0;
        end
        S_ROT: begin
          if (cnt == CORDIC_LAST) begin
            state <= S_ROT_SAVE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROT_SAVE: begin
          state <= sel ? S_GRAV_A : S_ROT_INIT;
          sel   <= !sel;
        end
        S_GRAV_A:    state <= S_GRAV_B;
        S_GRAV_B:    state <= S_SQ_EX;
        S_SQ_EX:     state <= S_SQ_EY;
        S_SQ_EY:     state <= S_SQ_EZ;
        S_SQ_EZ: begin
          state <= S_SQRT_INIT;
          late  <= 1'b1;
        end
        S_DECIDE:    state <= sts.hit ? S_VEL_A : S_IDLE;
        S_VEL_A:     state <= S_VEL_B;
        S_VEL_B: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/imusd_dp.sv */
// ----------------------------------------------------------------------------
// imusd_dp
// Datapath: shared CORDIC, square root, filter, threshold and hit logic.
// ----------------------------------------------------------------------------
`default_nettype none

module imusd_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  imusd_pkg::cmd_t                      cmd,
  output imusd_pkg::sts_t                      sts,
  input  imusd_pkg::in_t                       in_data,
  input  logic                                 cfg_we,
  input  logic [imusd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imusd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output imusd_pkg::out_t                      out_data
);

  localparam int D_LAST = imusd_pkg::CURVE_TABLE_DEPTH - 1;
  localparam int N_MAX  = imusd_pkg::PEAK_SPAN * D_LAST + imusd_pkg::PEAK_SPAN / 2;
  localparam int N_W    = $clog2(N_MAX + 1);
  localparam int VQ_W   = N_W - 12;
  localparam int P_W    = VQ_W + 17;
  localparam int VI_W   = P_W - imusd_pkg::RECIP7_SH;

  localparam logic signed [24:0] A_FULL    = 25'(imusd_pkg::ANG_FULL);
  localparam logic signed [24:0] A_HALF    = 25'(imusd_pkg::ANG_HALF);
  localparam logic signed [24:0] A_QUARTER = 25'(imusd_pkg::ANG_QUARTER);
  localparam logic signed [42:0] A_MAX     = 43'(imusd_pkg::ANG_MAX);
  localparam logic signed [55:0] RND37     = 56'sd1 <<< 36;

  imusd_pkg::in_t       smp;
  logic [35:0]          sum_r;
  logic [35:0]          sq_op;
  logic [19:0]          sq_rem;
  logic [17:0]          sq_root;
  logic signed [27:0]   cx;
  logic signed [27:0]   cy;
  logic signed [23:0]   cz;
  logic                 czero;
  logic                 vmode;
  logic                 cneg;
  logic signed [23:0]   acc_roll;
  logic signed [23:0]   acc_pitch;
  logic signed [17:0]   inc_r;
  logic signed [41:0]   blend_t;
  logic signed [23:0]   roll;
  logic signed [23:0]   pitch;
  logic signed [27:0]   sr;
  logic signed [27:0]   cr;
  logic signed [27:0]   sp;
  logic signed [27:0]   cp;
  logic signed [17:0]   ex;
  logic signed [17:0]   ey;
  logic signed [17:0]   ez;
  logic [23:0]          live_thr;
  logic                 capturing;
  logic [17:0]          peak;
  logic [31:0]          win_start;
  logic [31:0]          last_hit;
  imusd_pkg::zone_t     hit_zone;
  logic [VQ_W-1:0]      vel_q;
  logic [9:0]           cooldown;
  logic [9:0]           peak_win;
  logic [15:0]          thr_floor;
  logic [15:0]          thr_ceil;
  logic [13:0]          side_lim;
  logic [13:0]          over_lim;

  logic signed [17:0]   sq_in;
  logic [35:0]          sq_pos;
  logic [21:0]          sq_t;
  logic [21:0]          sq_trial;
  logic signed [17:0]   vx0;
  logic signed [17:0]   vy0;
  logic signed [27:0]   xs;
  logic signed [27:0]   ys;
  logic signed [27:0]   cdx;
  logic signed [27:0]   cdy;
  logic signed [23:0]   cat;
  logic                 cup;
  logic signed [24:0]   ra0;
  logic signed [24:0]   ra1;
  logic signed [24:0]   ra2;
  logic                 rneg;
  logic signed [34:0]   gprod;
  logic signed [24:0]   bsum;
  logic signed [42:0]   bval;
  logic signed [42:0]   bsh;
  logic signed [23:0]   bnew;
  logic signed [55:0]   gprod_a;
  logic signed [55:0]   gprod_b;
  logic signed [27:0]   gx_r;
  logic [26:0]          mag_x512;
  logic signed [25:0]   thr_a;
  logic signed [25:0]   thr_b;
  logic signed [25:0]   thr_c;
  logic signed [25:0]   thr_lo;
  logic signed [25:0]   thr_hi;
  logic                 trig;
  logic                 cool;
  logic                 expired;
  logic [17:0]          pk_max;
  imusd_pkg::zone_t     zone_c;
  logic signed [24:0]   side_s;
  logic signed [24:0]   over_s;
  logic [17:0]          pk_c;
  logic [N_W-1:0]       vel_n;
  logic [P_W-1:0]       vel_p;
  logic [VI_W-1:0]      vel_i;
  logic [imusd_pkg::VEL_W-1:0] vel_idx;

  always_comb begin
    unique case (cmd.idx)
      imusd_pkg::SQ_AY: sq_in = 18'(smp.accel_y);
      imusd_pkg::SQ_AZ: sq_in = 18'(smp.accel_z);
      imusd_pkg::SQ_EX: sq_in = ex;
      imusd_pkg::SQ_EY: sq_in = ey;
      default:          sq_in = ez;
    endcase
    sq_pos   = 36'(sq_in * sq_in);
    sq_t     = {sq_rem, sq_op[35:34]};
    sq_trial = {2'b00, sq_root, 2'b01};
  end

  always_comb begin
    vy0 = cmd.sel ? -18'(smp.accel_x) : 18'(smp.accel_y);
    vx0 = cmd.sel ? $signed({1'b0, sq_root[16:0]}) : 18'(smp.accel_z);
    xs  = 28'(vx0) <<< 8;
    ys  = 28'(vy0) <<< 8;
    cdx = cy >>> cmd.idx;
    cdy = cx >>> cmd.idx;
    cat = $signed({4'b0000, imusd_pkg::ATAN_TAB[cmd.idx]});
    cup = vmode ? (cy > 28'sd0) : (cz < 24'sd0);
  end

  always_comb begin
    ra0 = 25'(cmd.sel ? pitch : roll);
    if (ra0 >= A_HALF) begin
      ra1 = ra0 - A_FULL;
    end else if (ra0 < -A_HALF) begin
      ra1 = ra0 + A_FULL;
    end else begin
      ra1 = ra0;
    end
    if (ra1 > A_QUARTER) begin
      ra2  = ra1 - A_HALF;
      rneg = 1'b1;
    end else if (ra1 < -A_QUARTER) begin
      ra2  = ra1 + A_HALF;
      rneg = 1'b1;
    end else begin
      ra2  = ra1;
      rneg = 1'b0;
    end
  end

  always_comb begin
    gprod = 35'(cmd.sel ? smp.gyro_y : smp.gyro_x) * 35'(imusd_pkg::GYRO_SCALE)
            + 35'sd32768;
    bsum  = 25'(cmd.sel ? pitch : roll) + 25'(inc_r);
    bval  = 43'(blend_t) + 43'(cmd.sel ? acc_pitch : acc_roll) * 43'(imusd_pkg::BLEND_ACC)
            + 43'sd16384;
    bsh   = bval >>> 15;
    if (bsh > A_MAX) begin
      bnew = 24'(A_MAX);
    end else if (bsh < -A_MAX - 43'sd1) begin
      bnew = 24'(-A_MAX - 43'sd1);
    end else begin
      bnew = 24'(bsh);
    end
    gprod_a = 56'(sr) * 56'(cp);
    gprod_b = 56'(cr) * 56'(cp);
    gx_r    = (sp + 28'sd4096) >>> 13;
  end

  always_comb begin
    mag_x512 = {sq_root, 9'b0};
    thr_a    = $signed({2'b00, live_thr});
    thr_b    = (mag_x512 > {3'b000, live_thr}) ? thr_a + 26'sd10486 : thr_a - 26'sd5243;
    thr_lo   = $signed({2'b00, thr_floor, 8'b0});
    thr_hi   = $signed({2'b00, thr_ceil, 8'b0});
    priority if (thr_b < thr_lo) begin
      thr_c = thr_lo;
    end else if (thr_b > thr_hi) begin
      thr_c = thr_hi;
    end else begin
      thr_c = thr_b;
    end
    trig    = {sq_root, 8'b0} > {2'b00, thr_c[23:0]};
    cool    = 32'(smp.time_ms - last_hit) < {22'b0, cooldown};
    expired = 32'(smp.time_ms - win_start) >= {22'b0, peak_win};
    pk_max  = (sq_root > peak) ? sq_root : peak;
    side_s  = $signed({3'b000, side_lim, 8'b0});
    over_s  = $signed({3'b000, over_lim, 8'b0});
    priority if (25'(pitch) > over_s) begin
      zone_c = imusd_pkg::ZONE_OVERHEAD;
    end else if (25'(roll) < -side_s) begin
      zone_c = imusd_pkg::ZONE_LEFT;
    end else if (25'(roll) > side_s) begin
      zone_c = imusd_pkg::ZONE_RIGHT;
    end else begin
      zone_c = imusd_pkg::ZONE_CENTER;
    end
    sts.hit = (cmd.op == imusd_pkg::OP_DECIDE) && !cool && capturing && expired;
  end

  always_comb begin
    if (peak < 18'(imusd_pkg::PEAK_LO)) begin
      pk_c = 18'(imusd_pkg::PEAK_LO);
    end else if (peak > 18'(imusd_pkg::PEAK_HI)) begin
      pk_c = 18'(imusd_pkg::PEAK_HI);
    end else begin
      pk_c = peak;
    end
    vel_n = N_W'(N_W'(pk_c - 18'(imusd_pkg::PEAK_LO)) * N_W'(D_LAST)
            + N_W'(imusd_pkg::PEAK_SPAN / 2));
    vel_p = P_W'(P_W'(vel_q) + P_W'(1)) * P_W'(imusd_pkg::RECIP7);
    vel_i = vel_p[P_W-1:imusd_pkg::RECIP7_SH];
    if (vel_i > VI_W'(D_LAST)) begin
      vel_idx = imusd_pkg::VEL_W'(D_LAST);
    end else begin
      vel_idx = vel_i[imusd_pkg::VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      imusd_pkg::OP_LOAD:     smp <= in_data;
      imusd_pkg::OP_SQ_FIRST: sum_r <= sq_pos;
      imusd_pkg::OP_SQ_ADD:   sum_r <= sum_r + sq_pos;
      imusd_pkg::OP_SQRT_INIT: begin
        sq_op   <= sum_r;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      imusd_pkg::OP_SQRT_STEP: begin
        sq_op <= {sq_op[33:0], 2'b00};
        if (sq_t >= sq_trial) begin
          sq_rem  <= 20'(sq_t - sq_trial);
          sq_root <= {sq_root[16:0], 1'b1};
        end else begin
          sq_rem  <= sq_t[19:0];
          sq_root <= {sq_root[16:0], 1'b0};
        end
      end
      imusd_pkg::OP_VEC_INIT: begin
        vmode <= 1'b1;
        czero <= (vx0 == 18'sd0) && (vy0 == 18'sd0);
        if (xs < 28'sd0) begin
          if (ys >= 28'sd0) begin
            cx <= ys;
            cy <= -xs;
            cz <= 24'(A_QUARTER);
          end else begin
            cx <= -ys;
            cy <= xs;
            cz <= 24'(-A_QUARTER);
          end
        end else begin
          cx <= xs;
          cy <= ys;
          cz <= 24'sd0;
        end
      end
      imusd_pkg::OP_CORDIC_STEP: begin
        if (cup) begin
          cx <= cx + cdx;
          cy <= cy - cdy;
          cz <= cz + cat;
        end else begin
          cx <= cx - cdx;
          cy <= cy + cdy;
          cz <= cz - cat;
        end
      end
      imusd_pkg::OP_VEC_SAVE: begin
        if (cmd.sel) begin
          acc_pitch <= czero ? 24'sd0 : cz;
        end else begin
          acc_roll <= czero ? 24'sd0 : cz;
        end
      end
      imusd_pkg::OP_GYRO:    inc_r <= 18'(gprod >>> 16);
      imusd_pkg::OP_BLEND_A: blend_t <= 42'(bsum) * 42'(imusd_pkg::BLEND_OLD);
      imusd_pkg::OP_ROT_INIT: begin
        vmode <= 1'b0;
        cneg  <= rneg;
        cx    <= 28'(imusd_pkg::GAIN_Q24);
        cy    <= 28'sd0;
        cz    <= 24'(ra2);
      end
      imusd_pkg::OP_ROT_SAVE: begin
        if (cmd.sel) begin
          sp <= cneg ? -cy : cy;
          cp <= cneg ? -cx : cx;
        end else begin
          sr <= cneg ? -cy : cy;
          cr <= cneg ? -cx : cx;
        end
      end
      imusd_pkg::OP_GRAV_A: ey <= 18'(smp.accel_y) + 18'((gprod_a + RND37) >>> 37);
      imusd_pkg::OP_GRAV_B: begin
        ez <= 18'(smp.accel_z) - 18'((gprod_b + RND37) >>> 37);
        ex <= 18'(smp.accel_x) - 18'(gx_r);
      end
      imusd_pkg::OP_DECIDE:  hit_zone <= zone_c;
      imusd_pkg::OP_VEL_A:   vel_q <= vel_n[N_W-1:12];
      imusd_pkg::OP_VEL_B: begin
        out_data.drum_note       <= imusd_pkg::note_of(hit_zone);
        out_data.zone            <= hit_zone;
        out_data.strike_velocity <= imusd_pkg::VEL_ROM[vel_idx];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll      <= '0;
      pitch     <= '0;
      live_thr  <= 24'(4096 * 256);
      capturing <= 1'b0;
      peak      <= '0;
      win_start <= '0;
      last_hit  <= '0;
      cooldown  <= 10'd50;
      peak_win  <= 10'd20;
      thr_floor <= 16'd3072;
      thr_ceil  <= 16'd7168;
      side_lim  <= 14'd1280;
      over_lim  <= 14'd1920;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          imusd_pkg::REG_COOLDOWN:    cooldown  <= cfg_data[9:0];
          imusd_pkg::REG_PEAK_WINDOW: peak_win  <= cfg_data[9:0];
          imusd_pkg::REG_THR_FLOOR:   thr_floor <= cfg_data;
          imusd_pkg::REG_THR_CEILING: thr_ceil  <= cfg_data;
          imusd_pkg::REG_SIDE_ROLL:   side_lim  <= cfg_data[13:0];
          imusd_pkg::REG_OVER_PITCH:  over_lim  <= cfg_data[13:0];
          default: ;
        endcase
      end
      if (cmd.op == imusd_pkg::OP_BLEND_B) begin
        if (cmd.sel) begin
          pitch <= bnew;
        end else begin
          roll <= bnew;
        end
      end
      if (cmd.op == imusd_pkg::OP_DECIDE) begin
        live_thr <= thr_c[23:0];
        if (!cool) begin
          if (!capturing) begin
            if (trig) begin
              capturing <= 1'b1;
              win_start <= smp.time_ms;
              peak      <= sq_root;
            end
          end else begin
            peak <= pk_max;
            if (expired) begin
              capturing <= 1'b0;
              last_hit  <= smp.time_ms;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/imu_strike_detector.sv */
// ----------------------------------------------------------------------------
// imu_strike_detector
// Air-drum strike detector: orientation filter, gravity removal and hit logic.
//
//   Channel   Signals                          Direction   Transfer when
//   in        in_valid, in_stall, in_data      sink        in_valid && !in_stall
//   out       out_valid, out_stall, out_data   source      out_valid && !out_stall
//   cfg       cfg_we, cfg_index, cfg_data      sink        cfg_we
//
// The time per sample is set by the shared CORDIC unit (four runs
// of 16 iterations) and the bit-serial square root (two runs of 18 steps).
// A hit waits in the output register while the next sample is already taken.
// Reset is synchronous and restores the filter, threshold and register values.
// A stalled output only delays the end of the sample that produces a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_strike_detector (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  imusd_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output imusd_pkg::out_t                   out_data,
  input  logic                              cfg_we,
  input  logic [imusd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imusd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  imusd_pkg::cmd_t cmd;
  imusd_pkg::sts_t sts;

  imusd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  imusd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/imu_strike_detector_tb.sv */
// ----------------------------------------------------------------------------
// imu_strike_detector_tb
// Self-checking bench: random and directed motion samples are sent through the
// detector, while an in-bench model of the orientation filter, gravity removal,
// adaptive threshold and hit window predicts every strike for comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_strike_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imusd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam int SETTLE = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  imu_strike_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state and register copies.
  longint m_roll, m_pitch, m_thr;
  logic m_capturing;
  logic [31:0] m_peak, m_wstart, m_lasthit;
  logic [31:0] r_cool, r_window, r_floor, r_ceil, r_side, r_over;
  logic [6:0] curve [CURVE_TABLE_DEPTH];
  longint atan_steps [24] = '{737280, 435242, 229970, 116736, 58595, 29326,
    14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};

  in_t pending_q [$];
  out_t strike_q [$];
  int pushed, accepted, hits, errors;
  bit in_fire, calm, pressed;
  int in_idle, out_idle;
  longint cycles;
  logic [31:0] t_now;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint tilt_angle(longint y, longint x);
    longint z, dx, dy, t;
    int n;
    z = 0;
    n = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ANG_QUARTER;
      end else begin
        x = -y; y = t; z = -ANG_QUARTER;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_steps[i];
      end else begin
        x -= dx; y += dy; z -= atan_steps[i];
      end
    end
    return z;
  endfunction

  task automatic sin_cos(input longint ang, output longint sn, output longint cs);
    longint a, x, y, dx, dy;
    bit neg;
    int n;
    n = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    a = ((ang % ANG_FULL) + ANG_FULL) % ANG_FULL;
    x = GAIN_Q24;
    y = 0;
    neg = 0;
    if (a >= ANG_HALF) a -= ANG_FULL;
    if (a > ANG_QUARTER) begin
      a -= ANG_HALF; neg = 1;
    end else if (a < -ANG_QUARTER) begin
      a += ANG_HALF; neg = 1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_steps[i];
      end else begin
        x += dx; y -= dy; a += atan_steps[i];
      end
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endtask

  function automatic longint fuse_angle(longint old, longint inc, longint acc);
    longint v;
    v = ((old + inc) * 32113 + acc * 655 + 16384) >>> 15;
    if (v > ANG_MAX) v = ANG_MAX;
    if (v < -ANG_MAX - 1) v = -ANG_MAX - 1;
    return v;
  endfunction

  task automatic model_reset();
    r_cool = 50; r_window = 20; r_floor = 3072; r_ceil = 7168;
    r_side = 1280; r_over = 1920;
    m_roll = 0; m_pitch = 0; m_thr = 4096 * 256;
    m_capturing = 0; m_peak = 0; m_wstart = 0; m_lasthit = 0;
  endtask

  // Works out whether a sample ends a strike window, and what it reports.
  task automatic predict_strike(input in_t s);
    longint ax, ay, az, ra, pa, sr, cr, sp, cp, ex, ey, ez, lo, hi, side, over;
    longint unsigned mag, pk, idx;
    zone_t zn;
    out_t o;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    ra = tilt_angle(ay, az);
    pa = tilt_angle(-ax, longint'(root_floor(ay * ay + az * az)));
    m_roll = fuse_angle(m_roll, (longint'(s.gyro_x) * GYRO_SCALE + 32768) >>> 16, ra);
    m_pitch = fuse_angle(m_pitch, (longint'(s.gyro_y) * GYRO_SCALE + 32768) >>> 16, pa);
    sin_cos(m_roll, sr, cr);
    sin_cos(m_pitch, sp, cp);
    ex = ax - ((sp + 4096) >>> 13);
    ey = ay + ((sr * cp + (64'sd1 <<< 36)) >>> 37);
    ez = az - ((cr * cp + (64'sd1 <<< 36)) >>> 37);
    mag = root_floor(ex * ex + ey * ey + ez * ez);
    if (longint'(mag) * 512 > m_thr) m_thr += THR_UP;
    else m_thr -= THR_DOWN;
    lo = longint'(r_floor) * 256;
    hi = longint'(r_ceil) * 256;
    if (m_thr < lo) m_thr = lo;
    else if (m_thr > hi) m_thr = hi;
    if (s.time_ms - m_lasthit < r_cool) return;
    if (!m_capturing) begin
      if (longint'(mag) * 256 > m_thr) begin
        m_capturing = 1;
        m_wstart = s.time_ms;
        m_peak = 32'(mag[17:0]);
      end
      return;
    end
    if (mag > m_peak) m_peak = 32'(mag[17:0]);
    if (s.time_ms - m_wstart < r_window) return;
    side = longint'(r_side) * 256;
    over = longint'(r_over) * 256;
    if (m_pitch > over) zn = ZONE_OVERHEAD;
    else if (m_roll < -side) zn = ZONE_LEFT;
    else if (m_roll > side) zn = ZONE_RIGHT;
    else zn = ZONE_CENTER;
    pk = m_peak;
    if (pk < PEAK_LO) pk = PEAK_LO;
    if (pk > PEAK_HI) pk = PEAK_HI;
    idx = ((pk - PEAK_LO) * (CURVE_TABLE_DEPTH - 1) + PEAK_SPAN / 2) / PEAK_SPAN;
    if (idx > CURVE_TABLE_DEPTH - 1) idx = CURVE_TABLE_DEPTH - 1;
    case (zn)
      ZONE_LEFT: o.drum_note = NOTE_LEFT;
      ZONE_RIGHT: o.drum_note = NOTE_RIGHT;
      ZONE_OVERHEAD: o.drum_note = NOTE_OVERHEAD;
      default: o.drum_note = NOTE_CENTER;
    endcase
    o.zone = zn;
    o.strike_velocity = curve[idx];
    strike_q.push_back(o);
    m_capturing = 0;
    m_lasthit = s.time_ms;
  endtask

  task automatic build_curve();
    longint unsigned d3, rhs, k, k5;
    d3 = longint'(CURVE_TABLE_DEPTH - 1) ** 3;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      rhs = longint'(i) * i * i * 64'd4984209207;
      k = 0;
      while (k < 87) begin
        k5 = (k + 1) * (k + 1) * (k + 1) * (k + 1) * (k + 1);
        if (k5 * d3 > rhs) break;
        k++;
      end
      curve[i] = 7'(40 + k);
    end
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Input driver: holds a stalled transfer, otherwise idles or offers the next sample.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_fire)) begin
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_valid <= 0;
      end else if (!calm && $urandom_range(15) == 0) begin
        in_idle <= $urandom_range(11);
        in_valid <= 0;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_stall <= 1;
      end else if (!calm && $urandom_range(15) == 0) begin
        out_idle <= $urandom_range(11);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // Monitor: checks strikes, then feeds accepted samples to the model.
  always @(posedge clk) begin
    out_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("imu_strike_detector_tb: done, errors");
      $finish;
    end
    in_fire <= in_valid && !in_stall && !rst;
    if (!rst && out_valid && !out_stall) begin
      hits++;
      if (strike_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected strike %p", $realtime, out_data);
      end else begin
        want = strike_q.pop_front();
        if (want.drum_note !== out_data.drum_note) begin
          errors++;
          $display("%0t: drum_note exp %0d got %0d", $realtime, want.drum_note,
                   out_data.drum_note);
        end
        if (want.zone !== out_data.zone) begin
          errors++;
          $display("%0t: zone exp %0d got %0d", $realtime, want.zone, out_data.zone);
        end
        if (want.strike_velocity !== out_data.strike_velocity) begin
          errors++;
          $display("%0t: strike_velocity exp %0d got %0d", $realtime,
                   want.strike_velocity, out_data.strike_velocity);
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      accepted++;
      predict_strike(in_data);
    end
  end

  task automatic add_sample(input int ax, ay, az, gx, gy, input logic [31:0] dt);
    in_t s;
    t_now = t_now + dt;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.gyro_x = 16'(gx); s.gyro_y = 16'(gy); s.time_ms = t_now;
    pending_q.push_back(s);
    pushed++;
  endtask

  task automatic drain();
    wait (accepted == pushed);
    wait (strike_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    case (idx)
      REG_COOLDOWN: r_cool = val & 32'h3ff;
      REG_PEAK_WINDOW: r_window = val & 32'h3ff;
      REG_THR_FLOOR: r_floor = val & 32'hffff;
      REG_THR_CEILING: r_ceil = val & 32'hffff;
      REG_SIDE_ROLL: r_side = val & 32'h3fff;
      REG_OVER_PITCH: r_over = val & 32'h3fff;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_regs(input int cool, win, flo, cei, side, over);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_PEAK_WINDOW, win);
    write_reg(REG_THR_FLOOR, flo);
    write_reg(REG_THR_CEILING, cei);
    write_reg(REG_SIDE_ROLL, side);
    write_reg(REG_OVER_PITCH, over);
  endtask

  function automatic int near(int base, int spread);
    return base + $signed($urandom_range(2 * spread)) - spread;
  endfunction

  // Mostly a hand held near rest with bursts of swing, plus raw noise and time jumps.
  task automatic random_motion(input int n);
    int kind, amp, ax, ay, az, gx, gy;
    logic [31:0] dt;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      dt = ($urandom_range(19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      if (kind < 10) begin
        add_sample($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(3) == 0 ? $urandom : dt);
      end else begin
        ax = near(0, 600); ay = near(0, 600); az = near(2048, 600);
        gx = near(0, 3000); gy = near(0, 3000);
        if (kind < 40) begin
          amp = $urandom_range(4000, 32000);
          case ($urandom_range(2))
            0: ax = near(0, amp);
            1: ay = near(0, amp);
            default: az = near(0, amp);
          endcase
          gx = near(0, 30000); gy = near(0, 30000);
        end
        if (ax > 32767) ax = 32767;
        if (ax < -32768) ax = -32768;
        if (ay > 32767) ay = 32767;
        if (ay < -32768) ay = -32768;
        if (az > 32767) az = 32767;
        if (az < -32768) az = -32768;
        add_sample(ax, ay, az, gx, gy, dt);
      end
      if (i % 50 == 49) wait (pending_q.size() < 20);
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0; in_data = '0; out_stall = 0;
    cfg_we = 0; cfg_index = REG_COOLDOWN; cfg_data = '0;
    in_fire = 0; in_idle = 0; out_idle = 0; calm = 0; pressed = 0;
    pushed = 0; accepted = 0; hits = 0; errors = 0; cycles = 0;
    build_curve();
    model_reset();
    t_now = 32'hffff_ff80;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed samples: field extremes, degenerate tilt, a swing and a time wrap.
    add_sample(0, 0, 0, 0, 0, 5);
    add_sample(-32768, -32768, -32768, -32768, -32768, 5);
    add_sample(32767, 32767, 32767, 32767, 32767, 5);
    add_sample(0, 100, -2048, 0, 0, 5);
    add_sample(0, -100, -2048, 0, 0, 5);
    add_sample(2048, 0, -5, 32767, -32768, 5);
    add_sample(-2048, 0, 0, -32768, 32767, 5);
    add_sample(0, 0, 2048, 0, 0, 60);
    add_sample(30000, 20000, -20000, 0, 0, 5);
    add_sample(20000, 0, 0, 0, 0, 10);
    add_sample(0, 0, 2048, 0, 0, 15);
    add_sample(0, 0, 2048, 0, 0, 5);
    for (int i = 0; i < 8; i++) add_sample(0, 32767, 2048, 32767, 0, 20);
    add_sample(0, -32768, 0, 0, -32768, 60);
    add_sample(-32768, 0, 2048, 0, 32767, 40);
    drain();

    set_regs(50, 20, 3072, 7168, 1280, 1920);
    random_motion(400);
    // Let every strike in flight come out before continuing.
    wait (accepted == pushed);
    wait (strike_q.size() == 0);
    pressed = 1;
    random_motion(100);
    drain();

    set_regs(0, 0, 0, 65535, 0, 0);
    write_reg(REG_SPARE, 16'hffff);
    write_reg(REG_SPARE + 1, 0);
    random_motion(350);
    drain();

    set_regs(1023, 1023, 65535, 65535, 11520, 11520);
    random_motion(120);
    drain();

    set_regs(10, 1, 9000, 2000, 400, 600);
    random_motion(350);
    drain();

    set_regs(0, 5, 2048, 4096, 11520, 0);
    random_motion(350);
    drain();

    calm = 1;
    set_regs(20, 10, 0, 0, 2000, 3000);
    random_motion(350);
    drain();

    $display("sent %0d samples over seven register settings, %0d strikes checked",
             accepted, hits);
    if (errors == 0) begin
      $display("imu_strike_detector_tb: done, clean");
    end else begin
      $display("imu_strike_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
